// ===== rtl/ecpi_pkg.sv =====
// ----------------------------------------------------------------------------
// ecpi_pkg
// Shared types and constants of the exact color palette indexer.
// ----------------------------------------------------------------------------
package ecpi_pkg;

  // field widths of the pixel and result words
  localparam int ChanW  = 8;
  localparam int WideW  = 16;
  localparam int IndexW = 8;
  localparam int CountW = 9;

  // controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_end;
  } status_t;

endpackage

// ===== rtl/exact_color_palette_indexer.sv =====
// ----------------------------------------------------------------------------
// exact_color_palette_indexer
// Assigns each RGB pixel an exact-match palette index, growing the palette
// in insertion order until it is full.
// ----------------------------------------------------------------------------
//  channel   handshake      payload
//  pixel     start / busy   red, green, blue, first_of_image
//  result    done strobe    index, added, overflow, red_wide, green_wide,
//                           blue_wide, color_count
//
// one palette entry is read per cycle while scanning; a hit ends the scan
// early, a miss reads every stored entry first, and a pixel on an empty
// palette commits without reading an entry.
// a new pixel may be started in the cycle done is high.
// reset clears the entry count but not the palette contents, which need no clearing.
// done is high for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module exact_color_palette_indexer #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [ecpi_pkg::ChanW-1:0]   red,
  input  logic [ecpi_pkg::ChanW-1:0]   green,
  input  logic [ecpi_pkg::ChanW-1:0]   blue,
  input  logic                         first_of_image,
  output logic                         done,
  output logic [ecpi_pkg::IndexW-1:0]  index,
  output logic                         added,
  output logic                         overflow,
  output logic [ecpi_pkg::WideW-1:0]   red_wide,
  output logic [ecpi_pkg::WideW-1:0]   green_wide,
  output logic [ecpi_pkg::WideW-1:0]   blue_wide,
  output logic [ecpi_pkg::CountW-1:0]  color_count
);

  ecpi_pkg::cmd_t    cmd;
  ecpi_pkg::status_t status;

  // controller
  ecpi_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // datapath
  ecpi_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .first_of_image (first_of_image),
    .index          (index),
    .added          (added),
    .overflow       (overflow),
    .red_wide       (red_wide),
    .green_wide     (green_wide),
    .blue_wide      (blue_wide),
    .color_count    (color_count)
  );

`ifndef SYNTHESIS
  // one result word per pixel, never two in a row
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // an accepted pixel keeps the block busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a pixel");

  // a word never reports both a new entry and an overflow
  a_added_xor_overflow: assert property (@(posedge clk) disable iff (rst)
    done |-> !(added && overflow))
    else $error("added and overflow both set");

  // the palette never grows past its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (color_count <= ecpi_pkg::CountW'(PALETTE_DEPTH)))
    else $error("color count beyond palette depth");
`endif

endmodule

// ===== rtl/ecpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// ecpi_ctrl
// Controller: accepts a pixel, runs the palette scan and commits the result.
// ----------------------------------------------------------------------------
module ecpi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ecpi_pkg::status_t status,
  output ecpi_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);

  ecpi_pkg::state_t state;
  ecpi_pkg::state_t state_next;

  // state register and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ecpi_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.commit;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ecpi_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ecpi_pkg::ST_SCAN;
        end
      end
      ecpi_pkg::ST_SCAN: begin
        if (status.hit || status.scan_end) begin
          cmd.commit = 1'b1;
          state_next = ecpi_pkg::ST_IDLE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      default: begin
        state_next = ecpi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ecpi_datapath.sv =====
// ----------------------------------------------------------------------------
// ecpi_datapath
// Palette memory, entry count, scan pointer, compare and result registers.
// ----------------------------------------------------------------------------
module ecpi_datapath #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ecpi_pkg::cmd_t               cmd,
  output ecpi_pkg::status_t            status,
  input  logic [ecpi_pkg::ChanW-1:0]   red,
  input  logic [ecpi_pkg::ChanW-1:0]   green,
  input  logic [ecpi_pkg::ChanW-1:0]   blue,
  input  logic                         first_of_image,
  output logic [ecpi_pkg::IndexW-1:0]  index,
  output logic                         added,
  output logic                         overflow,
  output logic [ecpi_pkg::WideW-1:0]   red_wide,
  output logic [ecpi_pkg::WideW-1:0]   green_wide,
  output logic [ecpi_pkg::WideW-1:0]   blue_wide,
  output logic [ecpi_pkg::CountW-1:0]  color_count
);

  localparam int AW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CW    = $clog2(PALETTE_DEPTH + 1);
  localparam int KeyW  = 3 * ecpi_pkg::ChanW;
  localparam logic [CW-1:0] Full = CW'(PALETTE_DEPTH);

  logic [KeyW-1:0] mem [PALETTE_DEPTH];
  logic [KeyW-1:0] rd_data;
  logic [KeyW-1:0] key;
  logic [CW-1:0]   count;
  logic [CW-1:0]   ptr;
  logic            pend_valid;
  logic [AW-1:0]   pend_addr;
  logic            hit;
  logic            full;
  logic            append;

  // compare the entry read last cycle against the pixel
  assign hit             = pend_valid && (rd_data == key);
  assign full            = (count == Full);
  assign append          = cmd.commit && !hit && !full;
  assign status.hit      = hit;
  assign status.scan_end = (ptr >= count) && !pend_valid;

  // palette memory write
  always_ff @(posedge clk) begin
    if (append) begin
      mem[count[AW-1:0]] <= key;
    end
  end

  // palette memory registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[ptr[AW-1:0]];
  end

  // entry count and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      ptr        <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.load) begin
      if (first_of_image) begin
        count <= '0;
      end
      ptr        <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.scan) begin
      pend_valid <= (ptr < count);
      if (ptr < count) begin
        ptr <= ptr + CW'(1);
      end
    end else if (append) begin
      count <= count + CW'(1);
    end
  end

  // scan address of the pending read, and pixel key
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      pend_addr <= ptr[AW-1:0];
    end
    if (cmd.load) begin
      key <= {red, green, blue};
    end
  end

  // result registers; widening by 257 is the byte repeated
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (hit) begin
        index       <= ecpi_pkg::IndexW'(pend_addr);
        added       <= 1'b0;
        overflow    <= 1'b0;
        color_count <= ecpi_pkg::CountW'(count);
      end else if (full) begin
        index       <= '0;
        added       <= 1'b0;
        overflow    <= 1'b1;
        color_count <= ecpi_pkg::CountW'(count);
      end else begin
        index       <= ecpi_pkg::IndexW'(count[AW-1:0]);
        added       <= 1'b1;
        overflow    <= 1'b0;
        color_count <= ecpi_pkg::CountW'(count + CW'(1));
      end
      if (!hit && full) begin
        red_wide   <= '0;
        green_wide <= '0;
        blue_wide  <= '0;
      end else begin
        red_wide   <= {2{key[KeyW-1 -: ecpi_pkg::ChanW]}};
        green_wide <= {2{key[2*ecpi_pkg::ChanW-1 -: ecpi_pkg::ChanW]}};
        blue_wide  <= {2{key[ecpi_pkg::ChanW-1:0]}};
      end
    end
  end

endmodule

// ===== dv/exact_color_palette_indexer_tb.sv =====
// ----------------------------------------------------------------------------
// exact_color_palette_indexer_tb
// Drives RGB pixels through start / busy and checks every result word
// against a palette lookup kept alongside the block: directed corner pixels,
// random images built from small color sets, and fills up to a full palette
// followed by hits and overflows.
// ----------------------------------------------------------------------------
module exact_color_palette_indexer_tb;

  localparam int ChanW  = ecpi_pkg::ChanW;
  localparam int WideW  = ecpi_pkg::WideW;
  localparam int IndexW = ecpi_pkg::IndexW;
  localparam int CountW = ecpi_pkg::CountW;

  localparam int PaletteDepth = 256;
  localparam int CycleLimit   = 2_000_000;
  localparam int TailCycles   = 300;

  // expected result word
  typedef struct packed {
    logic [IndexW-1:0] index;
    logic              added;
    logic              overflow;
    logic [WideW-1:0]  red_wide;
    logic [WideW-1:0]  green_wide;
    logic [WideW-1:0]  blue_wide;
    logic [CountW-1:0] color_count;
  } palette_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [ChanW-1:0]  red = '0;
  logic [ChanW-1:0]  green = '0;
  logic [ChanW-1:0]  blue = '0;
  logic              first_of_image = 1'b0;
  logic              done;
  logic [IndexW-1:0] index;
  logic              added;
  logic              overflow;
  logic [WideW-1:0]  red_wide;
  logic [WideW-1:0]  green_wide;
  logic [WideW-1:0]  blue_wide;
  logic [CountW-1:0] color_count;

  // shadow palette and its fill level
  logic [3*ChanW-1:0] palette_mem [PaletteDepth];
  int unsigned        color_total = 0;

  palette_result_t    pending_results [$];
  int unsigned        mismatch_count = 0;
  int unsigned        cycle_count = 0;
  int unsigned        burst_left = 0;

  exact_color_palette_indexer #(
    .PALETTE_DEPTH(PaletteDepth)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .first_of_image(first_of_image),
    .done          (done),
    .index         (index),
    .added         (added),
    .overflow      (overflow),
    .red_wide      (red_wide),
    .green_wide    (green_wide),
    .blue_wide     (blue_wide),
    .color_count   (color_count)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // exact-match lookup, appends on a miss while there is room
  function automatic palette_result_t lookup_palette(input logic [ChanW-1:0] r,
                                                     input logic [ChanW-1:0] g,
                                                     input logic [ChanW-1:0] b,
                                                     input logic first);
    palette_result_t res;
    logic [3*ChanW-1:0] key;
    bit hit;
    int j;
    key = {r, g, b};
    hit = 1'b0;
    res = '0;
    if (first) color_total = 0;
    for (j = 0; j < color_total; j++) begin
      if (!hit && palette_mem[j] == key) begin
        res.index = j[IndexW-1:0];
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (color_total >= PaletteDepth) begin
        res.overflow = 1'b1;
      end else begin
        res.index = color_total[IndexW-1:0];
        palette_mem[color_total] = key;
        color_total++;
        res.added = 1'b1;
      end
    end
    // widened channels, zero when nothing was stored
    if (!res.overflow) begin
      res.red_wide   = WideW'(r) * WideW'(257);
      res.green_wide = WideW'(g) * WideW'(257);
      res.blue_wide  = WideW'(b) * WideW'(257);
    end
    res.color_count = color_total[CountW-1:0];
    return res;
  endfunction

  // channel value with extra weight on the extremes
  function automatic logic [ChanW-1:0] pick_channel();
    int unsigned sel;
    sel = $urandom_range(7, 0);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return ChanW'($urandom_range(255, 0));
  endfunction

  function automatic logic [3*ChanW-1:0] pick_color();
    return {pick_channel(), pick_channel(), pick_channel()};
  endfunction

  // one pixel word; start stays high so back-to-back words need no re-raise
  task automatic send_pixel(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                            input logic [ChanW-1:0] b, input logic first);
    start          <= 1'b1;
    red            <= r;
    green          <= g;
    blue           <= b;
    first_of_image <= first;
    do @(posedge clk); while (busy);
    pending_results.push_back(lookup_palette(r, g, b, first));
  endtask

  task automatic send_color(input logic [3*ChanW-1:0] c, input logic first);
    send_pixel(c[3*ChanW-1:2*ChanW], c[2*ChanW-1:ChanW], c[ChanW-1:0], first);
  endtask

  // bursts of random length, random gaps between them
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // hold off until every expected word has come back
  task automatic wait_palette_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string fname, input logic [WideW-1:0] want,
                             input logic [WideW-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
                 fname, cycle_count, want, got);
    end
  endtask

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    palette_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word at cycle %0d: index %0d", cycle_count, index);
      end else begin
        want = pending_results.pop_front();
        check_field("index", WideW'(want.index), WideW'(index));
        check_field("added", WideW'(want.added), WideW'(added));
        check_field("overflow", WideW'(want.overflow), WideW'(overflow));
        check_field("red_wide", want.red_wide, red_wide);
        check_field("green_wide", want.green_wide, green_wide);
        check_field("blue_wide", want.blue_wide, blue_wide);
        check_field("color_count", WideW'(want.color_count), WideW'(color_count));
      end
    end
  end

  // corner pixels, hits, appends and image restarts
  task automatic test_directed();
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hff, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hff, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hff, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'h00, 8'hff, 8'h00, 1'b0);
    send_pixel(8'haa, 8'h55, 8'haa, 1'b0);
    send_pixel(8'h55, 8'haa, 8'h55, 1'b0);
    send_pixel(8'haa, 8'h55, 8'haa, 1'b0);
    // restart drops old entries, the same colors append again
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'hff, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
    send_pixel(8'h01, 8'h80, 8'hfe, 1'b0);
    send_pixel(8'hfe, 8'h7f, 8'h01, 1'b0);
  endtask

  // images drawn mostly from a small color set, some pixels off the set
  task automatic test_random_images(input int unsigned n_pixels);
    logic [3*ChanW-1:0] pool [$];
    logic [3*ChanW-1:0] c;
    int unsigned sent;
    int unsigned pool_size;
    int unsigned len;
    int unsigned k;
    bit clear;
    sent = 0;
    while (sent < n_pixels) begin
      pool.delete();
      pool_size = ($urandom_range(9, 0) == 0) ? $urandom_range(48, 12)
                                              : $urandom_range(8, 1);
      for (k = 0; k < pool_size; k++) pool.push_back(pick_color());
      len = $urandom_range(60, 1);
      clear = ($urandom_range(9, 0) != 0);
      for (k = 0; k < len && sent < n_pixels; k++) begin
        pace_sender();
        if ($urandom_range(4, 0) == 0) c = pick_color();
        else c = pool[$urandom_range(pool.size() - 1, 0)];
        send_color(c, clear && k == 0);
        sent++;
      end
    end
  endtask

  // fill the palette, then mix hits with overflowing misses
  task automatic test_palette_overflow(input int unsigned n_extra);
    logic [3*ChanW-1:0] c;
    bit first;
    int unsigned k;
    int unsigned sel;
    first = 1'b1;
    while (first || color_total < PaletteDepth) begin
      pace_sender();
      send_color((3*ChanW)'($urandom()), first);
      first = 1'b0;
    end
    for (k = 0; k < n_extra; k++) begin
      pace_sender();
      sel = $urandom_range(5, 0);
      case (sel)
        0: c = palette_mem[0];
        1: c = palette_mem[PaletteDepth-1];
        2, 3: c = palette_mem[$urandom_range(PaletteDepth - 1, 0)];
        default: c = pick_color();
      endcase
      send_color(c, 1'b0);
    end
    // restart from a full palette
    pace_sender();
    send_color(pick_color(), 1'b1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    wait_palette_idle();
    test_random_images(900);
    wait_palette_idle();
    test_palette_overflow(60);
    wait_palette_idle();
    test_palette_overflow(60);

    // drain and let the block settle
    wait_palette_idle();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
